// ===== rtl/core/sspq_pkg.sv =====
`timescale 1ns / 1ps

package sspq_pkg;

	localparam int DATA_W  = 32;
	localparam int PRIO_W  = 8;
	localparam int COUNT_W = 5;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_PEEK    = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic signed [DATA_W-1:0] in_data;
		logic [PRIO_W-1:0]        in_priority;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] head_data;
		logic [PRIO_W-1:0]        head_priority;
		logic [COUNT_W-1:0]       entry_count;
		logic [STAT_W-1:0]        status;
	} rsp_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [PRIO_W-1:0]        prio;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/sspq_cell.sv =====
`timescale 1ns / 1ps

module sspq_cell (
	input  logic                 clk,
	input  sspq_pkg::cell_ctrl_t ctrl,
	input  logic                 occ,
	input  logic                 left_gt,
	input  sspq_pkg::entry_t     new_entry,
	input  sspq_pkg::entry_t     left_entry,
	input  sspq_pkg::entry_t     right_entry,
	output sspq_pkg::entry_t     entry,
	output logic                 gt
);

	sspq_pkg::entry_t entry_q;

	// an empty cell counts as larger, so the new entry lands at the tail
	assign gt    = !occ || (entry_q.prio > new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.enq && gt) begin
			entry_q <= left_gt ? left_entry : new_entry;
		end else if (ctrl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== rtl/core/stable_sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps
// A result is valid in the cycle after its request transaction is accepted.
// Throughput: one request per cycle while rsp_ready is high; every cell of the
// sorted chain compares and shifts in the same cycle, and the result register
// frees as it is taken. Reset (arst_n low) empties the queue and drops any
// pending result; cell contents are not cleared and are only read once written.

module stable_sorted_priority_queue_top #(
	parameter int CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  sspq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output sspq_pkg::rsp_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_next;
	logic                 rsp_valid_q;
	sspq_pkg::rsp_t       rsp_q;
	sspq_pkg::rsp_t       rsp_next;
	sspq_pkg::cell_ctrl_t ctrl;
	sspq_pkg::entry_t     new_entry;
	sspq_pkg::entry_t     head_next;
	sspq_pkg::entry_t     cell_entry [CAPACITY];
	logic                 cell_gt    [CAPACITY];
	logic                 accept;
	logic                 is_full;
	logic                 is_empty;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	assign new_entry.data = req.in_data;
	assign new_entry.prio = req.in_priority;

	always_comb begin
		ctrl            = '0;
		count_next      = count_q;
		head_next       = cell_entry[0];
		rsp_next.status = sspq_pkg::ST_OK;
		case (req.operation)
			sspq_pkg::OP_ENQUEUE: begin
				if (is_full) begin
					rsp_next.status = sspq_pkg::ST_FULL;
				end else begin
					ctrl.enq   = accept;
					count_next = count_q + 1'b1;
					if (cell_gt[0]) head_next = new_entry;
				end
			end
			sspq_pkg::OP_DEQUEUE: begin
				if (is_empty) begin
					rsp_next.status = sspq_pkg::ST_EMPTY;
				end else begin
					ctrl.deq   = accept;
					count_next = count_q - 1'b1;
					head_next  = cell_entry[1];
				end
			end
			sspq_pkg::OP_PEEK: begin
				if (is_empty) rsp_next.status = sspq_pkg::ST_EMPTY;
			end
			default: ;
		endcase
		if (count_next == '0) begin
			rsp_next.head_data     = '0;
			rsp_next.head_priority = '0;
		end else begin
			rsp_next.head_data     = head_next.data;
			rsp_next.head_priority = head_next.prio;
		end
		rsp_next.entry_count = sspq_pkg::COUNT_W'(count_next);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic             occ;
		logic             left_gt;
		sspq_pkg::entry_t left_entry;
		sspq_pkg::entry_t right_entry;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_gt    = 1'b0;
			assign left_entry = new_entry;
		end else begin : g_mid
			assign left_gt    = cell_gt[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = new_entry;
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		sspq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (occ),
			.left_gt     (left_gt),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (cell_entry[i]),
			.gt          (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) rsp_q <= rsp_next;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> cell_entry[0].prio <= cell_entry[1].prio)
		else $error("head cells out of order");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enq |=> count_q == $past(count_q) + 1'b1)
		else $error("enqueue did not grow the count");

	a_deq_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.deq |=> count_q == $past(count_q) - 1'b1)
		else $error("dequeue did not shrink the count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == sspq_pkg::ST_EMPTY
		|-> rsp_q.head_data == '0 && rsp_q.head_priority == '0)
		else $error("empty result carries a head entry");

endmodule
